FILE: design/twpd_pkg.sv
// ----------------------------------------------------------------------------
// twpd_pkg: shared constants of the three window peak detector
// Field widths, internal sum widths and parameter defaults.
// ----------------------------------------------------------------------------
package twpd_pkg;
  localparam int SAMPLE_W       = 32;
  localparam int CENTER_W       = 32;
  localparam int HEIGHT_W       = 40;
  localparam int SUM_W          = 40;
  localparam int DET_W          = 42;
  localparam int HSUM_W         = 64;
  localparam int WIN_CFG_W      = 7;
  localparam int WIN_RESET      = 10;
  localparam int DEF_MAX_WINDOW = 64;
  localparam int DEF_MAX_BINS   = 65536;
endpackage

FILE: design/twpd_in_if.sv
// ----------------------------------------------------------------------------
// twpd_in_if: input bin channel
// Valid/ready channel carrying one spectrum bin per item.
// ----------------------------------------------------------------------------
interface twpd_in_if
  import twpd_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] clipped_sample;
  logic        [CENTER_W-1:0] bin_center;
  logic                       last_bin;

  modport source (output valid, clipped_sample, bin_center, last_bin, input ready);
  modport sink   (input valid, clipped_sample, bin_center, last_bin, output ready);
endinterface

FILE: design/twpd_out_if.sv
// ----------------------------------------------------------------------------
// twpd_out_if: peak result channel
// Valid/ready channel carrying one peak or end-of-spectrum result per item.
// ----------------------------------------------------------------------------
interface twpd_out_if
  import twpd_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                peak_valid;
  logic [CENTER_W-1:0] peak_position;
  logic [HEIGHT_W-1:0] peak_height;
  logic                spectrum_done;
  logic                no_peaks_found;

  modport source (output valid, peak_valid, peak_position, peak_height, spectrum_done,
                  no_peaks_found, input ready);
  modport sink   (input valid, peak_valid, peak_position, peak_height, spectrum_done,
                  no_peaks_found, output ready);
endinterface

FILE: design/twpd_cfg_if.sv
// ----------------------------------------------------------------------------
// twpd_cfg_if: configuration write channel
// Valid/ready channel carrying the window width register.
// ----------------------------------------------------------------------------
interface twpd_cfg_if
  import twpd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [WIN_CFG_W-1:0] window_bins;

  modport source (output valid, window_bins, input ready);
  modport sink   (input valid, window_bins, output ready);
endinterface

FILE: design/twpd_div.sv
// ----------------------------------------------------------------------------
// twpd_div: restoring divider
// Unsigned HSUM_W by DIV_W bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twpd_div
  import twpd_pkg::*;
#(
  parameter int DIV_W = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HSUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [HSUM_W-1:0] quotient
);
  localparam int CNT_W = $clog2(HSUM_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [HSUM_W-1:0] quo_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dvs_r;
  logic [DIV_W:0]    trial;
  logic              fits;

  // trial subtract of the shifted remainder
  assign trial = {rem_r, quo_r[HSUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        // advance one quotient bit
        quo_r <= {quo_r[HSUM_W-2:0], fits};
        rem_r <= fits ? DIV_W'(trial - {1'b0, dvs_r}) : trial[DIV_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(HSUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

FILE: design/three_window_peak_detector.sv
// ----------------------------------------------------------------------------
// three_window_peak_detector: CFAR style peak finder with run centroid
// Three running window sums over ring memories, run accumulation and a
// shared serial divider for the run means.
// ----------------------------------------------------------------------------
// Sequencing: an accepted item passes S_T1, S_T2, S_T3, S_UPD, S_DET, S_ACC and S_DEC
// before ready returns; a closing run adds two divider passes (height, then position).
// A new item is taken only after the last is through, as the single read port of the
// sample ring reads the three taps in turn; a final bin or a closed peak also passes S_EMIT.
// Reset: synchronous active low; window returns to 10, spectrum state clears.
// Ring memories are not cleared; taps older than the spectrum read as zero.
module three_window_peak_detector
  import twpd_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int MAX_BINS   = DEF_MAX_BINS
) (
  input  logic clk,
  input  logic rst_n,
  twpd_in_if.sink    in_ch,
  twpd_out_if.source out_ch,
  twpd_cfg_if.sink   cfg_ch
);
  localparam int RING   = 3 * MAX_WINDOW;
  localparam int PTR_W  = $clog2(RING);
  localparam int ADR_W  = $clog2(2 * RING);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int DLY_W  = $clog2(RING + 1);
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int PSUM_W = CENTER_W + CNT_W;
  localparam int CMP_W  = (DLY_W > CNT_W) ? DLY_W : CNT_W;
  localparam int CLW    = (WIN_W > WIN_CFG_W) ? WIN_W : WIN_CFG_W;
  localparam int W_RST  = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;

  typedef enum logic [3:0] {
    S_IDLE, S_T1, S_T2, S_T3, S_UPD, S_DET, S_ACC, S_DEC, S_DIVH, S_DIVP, S_EMIT
  } state_t;

  state_t                     state_r;
  logic        [WIN_W-1:0]    win_r;
  logic        [PTR_W-1:0]    wp_r;
  logic        [CNT_W-1:0]    bins_r;
  logic signed [SUM_W-1:0]    lsum_r, msum_r, rsum_r;
  logic        [HSUM_W-1:0]   hsum_r;
  logic        [PSUM_W-1:0]   psum_r;
  logic        [CNT_W-1:0]    run_len_r;
  logic                       any_peak_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic        [CENTER_W-1:0] ctr_in_r;
  logic                       last_r;
  logic signed [SAMPLE_W-1:0] t1_r, t2_r;
  logic        [CENTER_W-1:0] ctr_r;
  logic signed [DET_W-1:0]    det_r;
  logic                       peak_r;
  logic        [HEIGHT_W-1:0] height_r;
  logic        [CENTER_W-1:0] pos_r;

  logic                       out_valid_r;
  logic                       out_peak_r;
  logic        [CENTER_W-1:0] out_pos_r;
  logic        [HEIGHT_W-1:0] out_height_r;
  logic                       out_done_r;
  logic                       out_none_r;

  logic signed [SAMPLE_W-1:0] smp_mem [RING];
  logic        [CENTER_W-1:0] ctr_mem [RING];
  logic signed [SAMPLE_W-1:0] smp_rd;
  logic        [CENTER_W-1:0] ctr_rd;
  logic        [PTR_W-1:0]    smp_addr;
  logic        [PTR_W-1:0]    ctr_addr;

  logic        [DLY_W-1:0]    d1, d2, d3, dc;
  logic signed [SAMPLE_W-1:0] t1_m, t2_m, t3_m;
  logic signed [DET_W-1:0]    det_c;
  logic                       have_det;
  logic                       close;
  logic                       div_start;
  logic        [HSUM_W-1:0]   div_dividend;
  logic                       div_done;
  logic        [HSUM_W-1:0]   div_quo;
  logic        [CLW-1:0]      cfg_v;
  logic        [WIN_W-1:0]    cfg_win;
  logic                       emit_ok;

  function automatic logic [PTR_W-1:0] tap(input logic [PTR_W-1:0] wp,
                                           input logic [DLY_W-1:0] d);
    logic [ADR_W-1:0] a;
    a = ADR_W'(wp) + ADR_W'(RING) - ADR_W'(d);
    if (a >= ADR_W'(RING)) a = a - ADR_W'(RING);
    return a[PTR_W-1:0];
  endfunction

  // tap delays for the current window
  assign d1 = DLY_W'(win_r);
  assign d2 = DLY_W'(2 * win_r);
  assign d3 = DLY_W'(3 * win_r);
  assign dc = DLY_W'(2 * win_r - 1 - ((win_r - 1) >> 1));

  // taps reaching before the spectrum start read as zero
  assign t1_m = (CMP_W'(d1) > CMP_W'(bins_r)) ? '0 : t1_r;
  assign t2_m = (CMP_W'(d2) > CMP_W'(bins_r)) ? '0 : t2_r;
  assign t3_m = (CMP_W'(d3) > CMP_W'(bins_r)) ? '0 : smp_rd;

  // sample ring read address steps through the three taps
  always_comb begin
    case (state_r)
      S_T2:    smp_addr = tap(wp_r, d2);
      S_T3:    smp_addr = tap(wp_r, d3);
      default: smp_addr = tap(wp_r, d1);
    endcase
  end
  assign ctr_addr = tap(wp_r, dc);

  // ring memories
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      smp_mem[wp_r] <= x_r;
      ctr_mem[wp_r] <= ctr_in_r;
    end
    smp_rd <= smp_mem[smp_addr];
    ctr_rd <= ctr_mem[ctr_addr];
  end

  // detector value from the updated sums
  assign have_det = CMP_W'(bins_r) >= CMP_W'(d3);
  assign det_c = have_det ? (DET_W'(msum_r) * 2 - DET_W'(lsum_r) - DET_W'(rsum_r)) : '0;
  assign close = ((det_r <= 0) || last_r) && (run_len_r != '0);

  // window register clamp
  assign cfg_v   = CLW'(cfg_ch.window_bins);
  assign cfg_win = (cfg_v == '0) ? WIN_W'(1) :
                   (cfg_v > CLW'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : WIN_W'(cfg_v);

  // shared divider: height mean first, then position mean
  assign div_start    = (state_r == S_DEC && close) || (state_r == S_DIVH && div_done);
  assign div_dividend = (state_r == S_DEC) ? hsum_r : HSUM_W'(psum_r);

  twpd_div #(
    .DIV_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (run_len_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign emit_ok = !out_valid_r || out_ch.ready;

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WIN_W'(W_RST);
      wp_r        <= '0;
      bins_r      <= '0;
      lsum_r      <= '0;
      msum_r      <= '0;
      rsum_r      <= '0;
      hsum_r      <= '0;
      psum_r      <= '0;
      run_len_r   <= '0;
      any_peak_r  <= 1'b0;
      peak_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a result once taken
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) out_valid_r <= 1'b0;

      // window write clears the spectrum
      if (cfg_ch.valid && cfg_ch.ready) begin
        win_r      <= cfg_win;
        wp_r       <= '0;
        bins_r     <= '0;
        lsum_r     <= '0;
        msum_r     <= '0;
        rsum_r     <= '0;
        hsum_r     <= '0;
        psum_r     <= '0;
        run_len_r  <= '0;
        any_peak_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            x_r      <= in_ch.clipped_sample;
            ctr_in_r <= in_ch.bin_center;
            last_r   <= in_ch.last_bin;
            peak_r   <= 1'b0;
            state_r  <= S_T1;
          end
        end
        S_T1: state_r <= S_T2;
        S_T2: begin
          t1_r    <= smp_rd;
          ctr_r   <= ctr_rd;
          state_r <= S_T3;
        end
        S_T3: begin
          t2_r    <= smp_rd;
          state_r <= S_UPD;
        end
        S_UPD: begin
          // advance the window sums and the ring
          rsum_r <= rsum_r + SUM_W'(x_r) - SUM_W'(t1_m);
          msum_r <= msum_r + SUM_W'(t1_m) - SUM_W'(t2_m);
          lsum_r <= lsum_r + SUM_W'(t2_m) - SUM_W'(t3_m);
          wp_r   <= (wp_r == PTR_W'(RING - 1)) ? '0 : wp_r + 1'b1;
          if (bins_r < CNT_W'(MAX_BINS)) bins_r <= bins_r + 1'b1;
          state_r <= S_DET;
        end
        S_DET: begin
          det_r   <= det_c;
          state_r <= S_ACC;
        end
        S_ACC: begin
          // extend the open run
          if (det_r > 0 && run_len_r < CNT_W'(MAX_BINS)) begin
            hsum_r    <= hsum_r + HSUM_W'($unsigned(det_r));
            psum_r    <= psum_r + PSUM_W'(ctr_r);
            run_len_r <= run_len_r + 1'b1;
          end
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (close) begin
            peak_r  <= 1'b1;
            state_r <= S_DIVH;
          end else if (last_r) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_DIVH: begin
          if (div_done) begin
            height_r <= div_quo[HEIGHT_W-1:0];
            state_r  <= S_DIVP;
          end
        end
        S_DIVP: begin
          if (div_done) begin
            pos_r   <= div_quo[CENTER_W-1:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (emit_ok) begin
            out_valid_r  <= 1'b1;
            out_peak_r   <= peak_r;
            out_pos_r    <= peak_r ? pos_r : '0;
            out_height_r <= peak_r ? height_r : '0;
            out_done_r   <= last_r;
            out_none_r   <= last_r && !(any_peak_r || peak_r);
            if (last_r) begin
              wp_r       <= '0;
              bins_r     <= '0;
              lsum_r     <= '0;
              msum_r     <= '0;
              rsum_r     <= '0;
              hsum_r     <= '0;
              psum_r     <= '0;
              run_len_r  <= '0;
              any_peak_r <= 1'b0;
            end else if (peak_r) begin
              any_peak_r <= 1'b1;
              hsum_r     <= '0;
              psum_r     <= '0;
              run_len_r  <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign cfg_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.peak_valid     = out_peak_r;
  assign out_ch.peak_position  = out_pos_r;
  assign out_ch.peak_height    = out_height_r;
  assign out_ch.spectrum_done  = out_done_r;
  assign out_ch.no_peaks_found = out_none_r;
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: three window peak detector
// Feeds spectra of bins through the detector under bursty input and a
// stalling result sink, predicts every peak and end-of-spectrum result from
// a behavioural model of the detector and compares them field by field.
// Directed bins cover field extremes, short and single-bin spectra and runs
// closed by the final bin; random spectra follow over several window widths.
// ----------------------------------------------------------------------------
module testbench;
  import twpd_pkg::*;

  localparam int RING_LEN    = 3 * DEF_MAX_WINDOW;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 20;

  typedef struct packed {
    logic                peak_valid;
    logic [CENTER_W-1:0] peak_position;
    logic [HEIGHT_W-1:0] peak_height;
    logic                spectrum_done;
    logic                no_peaks_found;
  } peak_res_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic        [CENTER_W-1:0] center;
    bit                         last;
    bit                         typed;
    peak_res_t                  res;
  } bin_row_t;

  logic clk;
  logic rst_n;

  twpd_in_if  in_ch ();
  twpd_out_if out_ch ();
  twpd_cfg_if cfg_ch ();

  three_window_peak_detector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted detector state
  longint      ring_sample [RING_LEN];
  bit [31:0]   ring_center [RING_LEN];
  int unsigned ring_wp;
  longint      sum_left, sum_mid, sum_right;
  int unsigned bin_count;
  bit [63:0]   acc_height, acc_pos;
  int unsigned acc_len;
  bit          peak_seen;
  int unsigned win;

  peak_res_t   expected_peaks [$];
  int          mismatches   = 0;
  int          bins_sent;
  int          results_seen = 0;
  int          peaks_seen   = 0;
  int          cycle_count  = 0;
  int          tx_burst;
  int          rx_mode      = 0;
  int          rx_stall     = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void clear_spectrum();
    foreach (ring_sample[i]) begin
      ring_sample[i] = 0;
      ring_center[i] = 0;
    end
    ring_wp    = 0;
    sum_left   = 0;
    sum_mid    = 0;
    sum_right  = 0;
    bin_count  = 0;
    acc_height = 0;
    acc_pos    = 0;
    acc_len    = 0;
    peak_seen  = 1'b0;
  endfunction

  function automatic int unsigned ring_slot(int unsigned delay);
    return (ring_wp + RING_LEN - (delay % RING_LEN)) % RING_LEN;
  endfunction

  function automatic longint sample_at(int unsigned delay);
    if (delay > bin_count) return 0;
    return ring_sample[ring_slot(delay)];
  endfunction

  // Advance the predictor by one bin; returns 1 when a result is due
  function automatic bit predict_bin(logic signed [31:0] s, logic [31:0] c, bit last,
                                     output peak_res_t res);
    longint      x, t1, t2, t3, det;
    bit [31:0]   c_aligned;
    int unsigned dly_c;
    bit          emit, peak;
    bit [63:0]   pos, hgt;
    x     = longint'(s);
    dly_c = 2 * win - 1 - (win - 1) / 2;
    t1    = sample_at(win);
    t2    = sample_at(2 * win);
    t3    = sample_at(3 * win);
    c_aligned = ring_center[ring_slot(dly_c)];
    sum_right += x - t1;
    sum_mid   += t1 - t2;
    sum_left  += t2 - t3;
    ring_sample[ring_wp] = x;
    ring_center[ring_wp] = c;
    ring_wp = (ring_wp + 1) % RING_LEN;
    if (bin_count < DEF_MAX_BINS) bin_count++;
    det  = (bin_count >= 3 * win) ? (2 * sum_mid - sum_left - sum_right) : 0;
    emit = 1'b0;
    peak = 1'b0;
    pos  = 0;
    hgt  = 0;
    if (det > 0) begin
      if (acc_len < DEF_MAX_BINS) begin
        acc_height += 64'(det);
        acc_pos    += 64'(c_aligned);
        acc_len++;
      end
    end
    if ((det <= 0 || last) && acc_len > 0) begin
      pos        = acc_pos / acc_len;
      hgt        = acc_height / acc_len;
      peak       = 1'b1;
      peak_seen  = 1'b1;
      acc_height = 0;
      acc_pos    = 0;
      acc_len    = 0;
      emit       = 1'b1;
    end
    if (last) emit = 1'b1;
    res.peak_valid     = peak;
    res.peak_position  = pos[31:0];
    res.peak_height    = hgt[39:0];
    res.spectrum_done  = last;
    res.no_peaks_found = last && !peak_seen;
    if (last) clear_spectrum();
    return emit;
  endfunction

  // Append one stimulus row to a table
  function automatic void add_row(ref bin_row_t rows [$], input bin_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %0s: got %0h, want %0h (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  // Hand one bin to the detector; the sender works in bursts with gaps
  task automatic send_bin(logic signed [31:0] s, logic [31:0] c, bit last,
                          bit typed = 1'b0, peak_res_t typed_res = '0);
    peak_res_t res;
    if (tx_burst == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      tx_burst = $urandom_range(1, 20);
    end
    tx_burst--;
    in_ch.valid          <= 1'b1;
    in_ch.clipped_sample <= s;
    in_ch.bin_center     <= c;
    in_ch.last_bin       <= last;
    do @(posedge clk); while (!in_ch.ready);
    bins_sent++;
    if (predict_bin(s, c, last, res))
      expected_peaks.insert(expected_peaks.size(), typed ? typed_res : res);
  endtask

  // Let every expected result drain and the block settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_peaks.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window(logic [6:0] v);
    wait_idle();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_bins <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    win = (v < 1) ? 1 : (v > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : v;
    clear_spectrum();
  endtask

  // One random spectrum of the given length
  task automatic send_spectrum(int unsigned len);
    int unsigned mode, period, base;
    logic signed [31:0] s;
    logic [31:0] c;
    mode   = $urandom_range(0, 9);
    period = $urandom_range(2, 4 * win + 4);
    base   = $urandom();
    for (int unsigned i = 0; i < len; i++) begin
      if (mode == 0)      s = $urandom();
      else if (mode == 1) s = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      else begin
        s = $signed($urandom_range(0, 64)) - 32;
        if ((i % period) < (period / 3 + 1)) s += $urandom_range(200, 60000);
      end
      c = (mode == 0 || $urandom_range(0, 15) == 0) ? $urandom() : base + i * 256;
      send_bin(s, c, i == len - 1);
    end
  endtask

  function automatic void build_directed(ref bin_row_t rows [$]);
    peak_res_t none_found;
    none_found = '{peak_valid: 1'b0, peak_position: '0, peak_height: '0,
                   spectrum_done: 1'b1, no_peaks_found: 1'b1};
    // Reset window of ten: short spectra with extreme fields report no peaks
    add_row(rows, '{32'sh7fffffff, 32'h00000000, 1'b0, 1'b0, '0});
    add_row(rows, '{32'sh80000000, 32'hffffffff, 1'b0, 1'b0, '0});
    add_row(rows, '{32'sh00000000, 32'h00000100, 1'b1, 1'b1, none_found});
    add_row(rows, '{32'sh80000000, 32'hffffffff, 1'b1, 1'b1, none_found});
  endfunction

  function automatic void build_narrow(ref bin_row_t rows [$]);
    // Window of one: an isolated peak, a run held open by the final bin, then alternating extremes
    int vals [12] = '{0, 0, 0, 1000, 0, 0, 0, 0, 0, 0, 500, 500};
    foreach (vals[i])
      add_row(rows, '{vals[i], 32'(i * 256), i == 11, 1'b0, '0});
    add_row(rows, '{32'sh7fffffff, 32'hffffffff, 1'b0, 1'b0, '0});
    add_row(rows, '{32'sh80000000, 32'h00000000, 1'b0, 1'b0, '0});
    add_row(rows, '{32'sh7fffffff, 32'hffffffff, 1'b0, 1'b0, '0});
    add_row(rows, '{32'sh80000000, 32'h00000000, 1'b0, 1'b0, '0});
    add_row(rows, '{32'sh7fffffff, 32'hffffffff, 1'b1, 1'b0, '0});
  endfunction

  // Result sink: stall on a changing pattern, check every accepted item
  always @(posedge clk) begin
    peak_res_t got, want;
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) rx_mode <= $urandom_range(0, 2);
    if (rx_stall > 0) begin
      rx_stall     <= rx_stall - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_mode == 0) begin
      out_ch.ready <= 1'b1;
    end else if (rx_mode == 1) begin
      out_ch.ready <= $urandom_range(0, 1);
    end else if ($urandom_range(0, 15) == 0) begin
      rx_stall     <= $urandom_range(5, 30);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.peak_valid, out_ch.peak_position, out_ch.peak_height,
              out_ch.spectrum_done, out_ch.no_peaks_found};
      results_seen++;
      if (got.peak_valid) peaks_seen++;
      if (expected_peaks.size() == 0) begin
        report_mismatch("unexpected result", 64'(got), '0);
      end else begin
        want = expected_peaks.pop_front();
        if (got.peak_valid !== want.peak_valid)
          report_mismatch("peak_valid", 64'(got.peak_valid), 64'(want.peak_valid));
        if (got.peak_position !== want.peak_position)
          report_mismatch("peak_position", 64'(got.peak_position),
                          64'(want.peak_position));
        if (got.peak_height !== want.peak_height)
          report_mismatch("peak_height", 64'(got.peak_height), 64'(want.peak_height));
        if (got.spectrum_done !== want.spectrum_done)
          report_mismatch("spectrum_done", 64'(got.spectrum_done),
                          64'(want.spectrum_done));
        if (got.no_peaks_found !== want.no_peaks_found)
          report_mismatch("no_peaks_found", 64'(got.no_peaks_found),
                          64'(want.no_peaks_found));
      end
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    bin_row_t    rows [$];
    logic [6:0]  widths [8];
    int unsigned phase_bins, len;
    widths    = '{7'd0, 7'd127, 7'd2, 7'd32, 7'd3, 7'd5, 7'd10, 7'd1};
    bins_sent = 0;
    tx_burst  = 0;
    win       = WIN_RESET;
    clear_spectrum();
    in_ch.valid          <= 1'b0;
    in_ch.clipped_sample <= '0;
    in_ch.bin_center     <= '0;
    in_ch.last_bin       <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.window_bins   <= '0;
    rst_n                <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bins at the reset window, then at a window of one
    build_directed(rows);
    foreach (rows[i]) send_bin(rows[i].sample, rows[i].center, rows[i].last,
                               rows[i].typed, rows[i].res);
    rows.delete();
    set_window(7'd1);
    build_narrow(rows);
    foreach (rows[i]) send_bin(rows[i].sample, rows[i].center, rows[i].last,
                               rows[i].typed, rows[i].res);

    // Random spectra over a sweep of window widths, clamped values included
    foreach (widths[k]) begin
      set_window(widths[k] == 7'd5 ? 7'($urandom_range(1, 40)) : widths[k]);
      phase_bins = 0;
      while (phase_bins < 30) begin
        if (win == DEF_MAX_WINDOW) len = $urandom_range(3 * win - 2, 3 * win + 8);
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 3 * win);
        else len = $urandom_range(3 * win, 3 * win + 40);
        send_spectrum(len);
        phase_bins += len;
      end
    end

    wait_idle();
    $display("Sent %0d bins; checked %0d results, %0d of them peaks",
             bins_sent, results_seen, peaks_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: sim.f
design/twpd_pkg.sv
design/twpd_in_if.sv
design/twpd_out_if.sv
design/twpd_cfg_if.sv
design/twpd_div.sv
design/three_window_peak_detector.sv
tb/testbench.sv
